// File: design/cld_pkg.sv
`default_nettype none

package cld_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        VS_LEAD   = 2'd0,
        VS_DIGITS = 2'd1,
        VS_TRAIL  = 2'd2,
        VS_BAD    = 2'd3
    } vstage_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD     = 3'd0,
        KIND_EMPTY_MSG   = 3'd1,
        KIND_NO_LENGTH   = 3'd2,
        KIND_EMPTY_VALUE = 3'd3,
        KIND_NON_DIGIT   = 3'd4,
        KIND_TOO_LONG    = 3'd5,
        KIND_TRUNCATED   = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       last_byte;
    } res_t;

    localparam int         CFG_BITS    = 24;
    localparam logic [CFG_BITS-1:0] MAX_LENGTH_RST = 24'hFFFFFF;

    localparam logic [3:0] PREFIX_LEN  = 4'd15;

    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_CAP_A  = 8'h41;
    localparam logic [7:0] CHAR_CAP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // lower-case header name, including the colon
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: design/cld_in_stage.sv
`default_nettype none

module cld_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     data_byte,
    input  wire logic           end_of_stream,
    input  wire logic           take,
    output logic                item_valid,
    output cld_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    cld_pkg::item_t item_reg;

    // hold the byte while the parser cannot advance
    assign in_stall   = valid_reg && !take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.data_byte     <= data_byte;
            item_reg.end_of_stream <= end_of_stream;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: design/cld_parser.sv
`default_nettype none

module cld_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cld_pkg::CFG_BITS-1:0]  cfg_data,
    input  wire logic                          step,
    input  wire cld_pkg::item_t                item,
    output logic                               res_valid,
    output cld_pkg::res_t                      res
);

    localparam int CMP_W = (LENGTH_BITS > cld_pkg::CFG_BITS) ? LENGTH_BITS : cld_pkg::CFG_BITS;
    localparam int NV_W  = LENGTH_BITS + 4;

    logic [cld_pkg::CFG_BITS-1:0] max_length_reg;

    cld_pkg::phase_t         phase_reg,     phase_next;
    logic [3:0]              match_pos_reg, match_pos_next;
    logic                    matching_reg,  matching_next;
    cld_pkg::vstage_t        vstage_reg,    vstage_next;
    logic [LENGTH_BITS-1:0]  acc_reg,       acc_next;
    logic                    ovf_reg,       ovf_next;
    logic [1:0]              line_cnt_reg,  line_cnt_next;
    logic                    last_cr_reg,   last_cr_next;
    logic                    seen_reg,      seen_next;
    logic [LENGTH_BITS-1:0]  msg_len_reg,   msg_len_next;
    logic [LENGTH_BITS-1:0]  remain_reg,    remain_next;
    logic                    started_reg,   started_next;

    logic [7:0]       c;
    logic             eos;
    logic             is_ws;
    logic             is_digit;
    logic [7:0]       c_lower;
    logic [3:0]       digit;
    logic [NV_W-1:0]  nv;
    logic             nv_over;
    logic             line_empty;
    logic             line_is_len;
    logic             too_long;
    logic             line_err_valid;
    cld_pkg::kind_t   line_err_kind;
    logic             line_ok_len;
    logic             eff_seen;
    logic [LENGTH_BITS-1:0] eff_len;

    assign c   = item.data_byte;
    assign eos = item.end_of_stream;

    assign is_ws    = (c == cld_pkg::CHAR_SPACE) ||
                      (c >= cld_pkg::CHAR_TAB && c <= cld_pkg::CHAR_CR);
    assign is_digit = (c >= cld_pkg::CHAR_ZERO) && (c <= cld_pkg::CHAR_NINE);
    assign c_lower  = (c >= cld_pkg::CHAR_CAP_A && c <= cld_pkg::CHAR_CAP_Z) ?
                      (c + cld_pkg::CASE_OFFSET) : c;
    assign digit    = 4'(c - cld_pkg::CHAR_ZERO);

    // acc * 10 + digit, saturating at the accumulator width
    assign nv      = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + NV_W'(digit);
    assign nv_over = |nv[NV_W-1:LENGTH_BITS];

    // end-of-line checks
    assign line_empty  = (line_cnt_reg == 2'd0) || (line_cnt_reg == 2'd1 && last_cr_reg);
    assign line_is_len = matching_reg && (match_pos_reg == cld_pkg::PREFIX_LEN);
    assign too_long    = ovf_reg || (CMP_W'(acc_reg) > CMP_W'(max_length_reg));

    always_comb
    begin
        line_err_valid = 1'b0;
        line_err_kind  = cld_pkg::KIND_EMPTY_VALUE;
        if (!line_empty && line_is_len)
        begin
            priority if (vstage_reg == cld_pkg::VS_LEAD)
            begin
                line_err_valid = 1'b1;
                line_err_kind  = cld_pkg::KIND_EMPTY_VALUE;
            end
            else if (vstage_reg == cld_pkg::VS_BAD)
            begin
                line_err_valid = 1'b1;
                line_err_kind  = cld_pkg::KIND_NON_DIGIT;
            end
            else if (too_long)
            begin
                line_err_valid = 1'b1;
                line_err_kind  = cld_pkg::KIND_TOO_LONG;
            end
            else
            begin
                line_err_valid = 1'b0;
            end
        end
    end

    assign line_ok_len = !line_empty && line_is_len && !line_err_valid;
    assign eff_seen    = seen_reg || line_ok_len;
    assign eff_len     = line_ok_len ? acc_reg : msg_len_reg;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        match_pos_next = match_pos_reg;
        matching_next  = matching_reg;
        vstage_next    = vstage_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        line_cnt_next  = line_cnt_reg;
        last_cr_next   = last_cr_reg;
        seen_next      = seen_reg;
        msg_len_next   = msg_len_reg;
        remain_next    = remain_reg;
        started_next   = started_reg;

        if (step)
        begin
            if (eos)
            begin
                phase_next     = cld_pkg::PH_HEADER;
                match_pos_next = 4'd0;
                matching_next  = 1'b1;
                vstage_next    = cld_pkg::VS_LEAD;
                acc_next       = '0;
                ovf_next       = 1'b0;
                line_cnt_next  = 2'd0;
                last_cr_next   = 1'b0;
                seen_next      = 1'b0;
                msg_len_next   = '0;
                remain_next    = '0;
                started_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    cld_pkg::PH_PAYLOAD:
                    begin
                        if (remain_reg <= LENGTH_BITS'(1))
                        begin
                            phase_next   = cld_pkg::PH_HEADER;
                            seen_next    = 1'b0;
                            msg_len_next = '0;
                            remain_next  = '0;
                            started_next = 1'b0;
                        end
                        else
                        begin
                            remain_next = remain_reg - LENGTH_BITS'(1);
                        end
                    end
                    cld_pkg::PH_HEADER:
                    begin
                        started_next = 1'b1;
                        if (c != cld_pkg::CHAR_LF)
                        begin
                            if (line_cnt_reg != 2'd3)
                            begin
                                line_cnt_next = line_cnt_reg + 2'd1;
                            end
                            last_cr_next = (c == cld_pkg::CHAR_CR);
                            if (matching_reg)
                            begin
                                if (match_pos_reg != cld_pkg::PREFIX_LEN)
                                begin
                                    if (c_lower != cld_pkg::prefix_char(match_pos_reg))
                                    begin
                                        matching_next = 1'b0;
                                    end
                                    else
                                    begin
                                        match_pos_next = match_pos_reg + 4'd1;
                                    end
                                end
                                else if (is_ws)
                                begin
                                    if (vstage_reg == cld_pkg::VS_DIGITS)
                                    begin
                                        vstage_next = cld_pkg::VS_TRAIL;
                                    end
                                end
                                else if (is_digit && (vstage_reg == cld_pkg::VS_LEAD ||
                                                      vstage_reg == cld_pkg::VS_DIGITS))
                                begin
                                    vstage_next = cld_pkg::VS_DIGITS;
                                    if (nv_over)
                                    begin
                                        ovf_next = 1'b1;
                                        acc_next = '1;
                                    end
                                    else
                                    begin
                                        acc_next = nv[LENGTH_BITS-1:0];
                                    end
                                end
                                else
                                begin
                                    vstage_next = cld_pkg::VS_BAD;
                                end
                            end
                        end
                        else
                        begin
                            match_pos_next = 4'd0;
                            matching_next  = 1'b1;
                            vstage_next    = cld_pkg::VS_LEAD;
                            acc_next       = '0;
                            ovf_next       = 1'b0;
                            line_cnt_next  = 2'd0;
                            last_cr_next   = 1'b0;
                            priority if (line_err_valid)
                            begin
                                phase_next = cld_pkg::PH_ERROR;
                            end
                            else if (!line_empty)
                            begin
                                if (line_ok_len)
                                begin
                                    seen_next    = 1'b1;
                                    msg_len_next = acc_reg;
                                end
                            end
                            else if (!seen_reg)
                            begin
                                phase_next = cld_pkg::PH_ERROR;
                            end
                            else if (msg_len_reg == '0)
                            begin
                                seen_next    = 1'b0;
                                msg_len_next = '0;
                                remain_next  = '0;
                                started_next = 1'b0;
                            end
                            else
                            begin
                                phase_next  = cld_pkg::PH_PAYLOAD;
                                remain_next = msg_len_reg;
                            end
                        end
                    end
                    default:
                    begin
                        // error phase: bytes dropped
                    end
                endcase
            end
        end
    end

    // result
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = cld_pkg::KIND_PAYLOAD;
        res.payload_byte = 8'h00;
        res.last_byte    = 1'b0;

        if (step)
        begin
            if (eos)
            begin
                priority if (phase_reg == cld_pkg::PH_PAYLOAD)
                begin
                    res_valid = 1'b1;
                    res.kind  = cld_pkg::KIND_TRUNCATED;
                end
                else if (phase_reg == cld_pkg::PH_HEADER && started_reg)
                begin
                    res_valid = 1'b1;
                    priority if (line_err_valid)
                        res.kind = line_err_kind;
                    else if (!eff_seen)
                        res.kind = cld_pkg::KIND_NO_LENGTH;
                    else if (eff_len == '0)
                        res.kind = cld_pkg::KIND_EMPTY_MSG;
                    else
                        res.kind = cld_pkg::KIND_TRUNCATED;
                end
                else
                begin
                    res_valid = 1'b0;
                end
            end
            else if (phase_reg == cld_pkg::PH_PAYLOAD)
            begin
                res_valid        = 1'b1;
                res.kind         = cld_pkg::KIND_PAYLOAD;
                res.payload_byte = c;
                res.last_byte    = (remain_reg <= LENGTH_BITS'(1));
            end
            else if (phase_reg == cld_pkg::PH_HEADER && c == cld_pkg::CHAR_LF)
            begin
                priority if (line_err_valid)
                begin
                    res_valid = 1'b1;
                    res.kind  = line_err_kind;
                end
                else if (line_empty && !seen_reg)
                begin
                    res_valid = 1'b1;
                    res.kind  = cld_pkg::KIND_NO_LENGTH;
                end
                else if (line_empty && msg_len_reg == '0)
                begin
                    res_valid = 1'b1;
                    res.kind  = cld_pkg::KIND_EMPTY_MSG;
                end
                else
                begin
                    res_valid = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= cld_pkg::MAX_LENGTH_RST;
            phase_reg      <= cld_pkg::PH_HEADER;
            match_pos_reg  <= 4'd0;
            matching_reg   <= 1'b1;
            vstage_reg     <= cld_pkg::VS_LEAD;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            line_cnt_reg   <= 2'd0;
            last_cr_reg    <= 1'b0;
            seen_reg       <= 1'b0;
            msg_len_reg    <= '0;
            remain_reg     <= '0;
            started_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_length_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            match_pos_reg <= match_pos_next;
            matching_reg  <= matching_next;
            vstage_reg    <= vstage_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            line_cnt_reg  <= line_cnt_next;
            last_cr_reg   <= last_cr_next;
            seen_reg      <= seen_next;
            msg_len_reg   <= msg_len_next;
            remain_reg    <= remain_next;
            started_reg   <= started_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cld_out_stage.sv
`default_nettype none

module cld_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           res_valid,
    input  wire cld_pkg::res_t  res,
    output logic                out_free,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [2:0]          kind,
    output logic [7:0]          payload_byte,
    output logic                last_byte
);

    logic          valid_reg;
    logic          valid_next;
    cld_pkg::res_t res_reg;

    // register can take a new result when empty or being drained this cycle
    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = out_free ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = res_reg.kind;
    assign payload_byte = res_reg.payload_byte;
    assign last_byte    = res_reg.last_byte;

endmodule

`default_nettype wire

// File: design/content_length_deframer_core.sv
// Content-Length deframer: takes one stream byte per clock while not stalled
// and, after the header block (lines ended by LF, "Content-Length:" matched
// without regard to case), forwards exactly that many payload bytes with
// last_byte on the final one; errors are reported as a single result with a
// nonzero kind and the rest of the stream is dropped until end_of_stream.
// Sustained rate is one byte per clock with no bubbles while out_stall is
// low. The input register holds a byte while the parser step works on it;
// its result lands in the output register at the next clock edge and leaves
// once out_stall is low. While out_stall holds a waiting result back, a byte
// already in the input register stalls the input; an empty input register
// still takes one more transfer. The user must write max_length through the
// always-ready cfg port only while idle; the block does not enforce this.
`default_nettype none

module content_length_deframer_core #(
    parameter int LENGTH_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] max_length,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_stream,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             last_byte
);

    logic           item_valid;
    cld_pkg::item_t item;
    logic           out_free;
    logic           step;
    logic           res_valid;
    cld_pkg::res_t  res;

    assign cfg_ready = 1'b1;
    assign step      = item_valid && out_free;

    cld_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .take          (out_free),
        .item_valid    (item_valid),
        .item          (item)
    );

    cld_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (max_length),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    cld_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .last_byte    (last_byte)
    );

endmodule

`default_nettype wire

// File: design/cld_checker.sv
`default_nettype none

module cld_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] kind,
    input  wire logic [7:0] payload_byte,
    input  wire logic       last_byte
);

    // a result held back by the sink stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) &&
                                   $stable(payload_byte) && $stable(last_byte))
        else $error("output changed while stalled");

    // only payload results carry data or a last mark
    a_non_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != cld_pkg::KIND_PAYLOAD) |-> (payload_byte == 8'h00) &&
                                                        !last_byte)
        else $error("non-payload result carries data");

    // backpressure upstream only comes from a stalled full output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind content_length_deframer_core cld_checker u_cld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last_byte    (last_byte)
);

`default_nettype wire
